// ----- rtl/core/sbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Stereo band matrix package
// Shared item types, coefficient format, mode codes and the prediction gain
// function used by the stereo band matrix decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sbm_pkg;

  // Sample and coefficient formats. Coefficients are Q5.14 in 20 bits.
  localparam int unsigned SAMPLE_BITS = 32;
  localparam int unsigned COEF_W      = 20;
  localparam int unsigned Q_FRAC      = 14;
  localparam int unsigned ALPHA_W     = 8;

  localparam logic signed [COEF_W-1:0] ONE_Q14       = COEF_W'(16384);
  localparam logic signed [COEF_W-1:0] MINUS_ONE_Q14 = -ONE_Q14;
  localparam logic signed [COEF_W-1:0] ZERO_Q14      = '0;

  // Offset of the DPCM alpha code.
  localparam logic [6:0] ALPHA_OFFSET = 7'd60;

  // Item kinds carried in the action field.
  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_LINE   = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAP_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_DELTA = 2'd2;

  // Stereo processing modes.
  typedef enum logic [1:0] {
    SAP_IDENTITY = 2'd0,
    SAP_MS_BAND  = 2'd1,
    SAP_MS_ALL   = 2'd2,
    SAP_PREDICT  = 2'd3
  } sbm_sap_e;

  // Matrix chosen by a band header.
  typedef enum logic [1:0] {
    KIND_IDENT    = 2'd0,
    KIND_MID_SIDE = 2'd1,
    KIND_PREDICT  = 2'd2
  } sbm_kind_e;

  typedef logic signed [COEF_W-1:0] sbm_coef_t;

  typedef struct packed {
    sbm_coef_t a;
    sbm_coef_t b;
    sbm_coef_t c;
    sbm_coef_t d;
  } sbm_matrix_t;

  // Header decision passed from the alpha stage to the matrix stage.
  typedef struct packed {
    sbm_kind_e                  kind;
    logic signed [ALPHA_W-1:0]  alpha;
  } sbm_dec_t;

  // Input item.
  typedef struct packed {
    logic                          action;
    logic [2:0]                    group_index;
    logic [5:0]                    band_index;
    logic [6:0]                    group_band_count;
    logic                          mid_side_used;
    logic                          coefficient_used;
    logic [6:0]                    alpha_code;
    logic signed [SAMPLE_BITS-1:0] line_left;
    logic signed [SAMPLE_BITS-1:0] line_right;
  } sbm_in_t;

  // Result item.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } sbm_out_t;

  // Prediction gain round(alpha * 0.1) in Q14, written as
  // |alpha| * 1638 + round(0.4 * |alpha|). The rounding term is
  // floor((4|alpha| + 5) / 10), taken as a multiply by 205 and a shift by 11,
  // which is exact for the small operand range here.
  function automatic sbm_coef_t gain_q14(input logic signed [ALPHA_W-1:0] alpha);
    logic [ALPHA_W-1:0] mag;
    logic [9:0]         x;
    logic [19:0]        prod_r;
    logic [5:0]         frac;
    logic [17:0]        whole;
    logic [COEF_W-1:0]  g;
    mag    = alpha[ALPHA_W-1] ? ALPHA_W'(-alpha) : ALPHA_W'(alpha);
    x      = {mag, 2'b00} + 10'd5;
    prod_r = 20'(x) * 20'd205;
    frac   = 6'(prod_r >> 11);
    whole  = 18'(mag) * 18'd1638;
    g      = COEF_W'(whole) + COEF_W'(frac);
    return alpha[ALPHA_W-1] ? $signed(-g) : $signed(g);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sbm_alpha.sv -----
// ----------------------------------------------------------------------------
// Stereo band matrix alpha stage
// Decodes band headers: tracks the window group, predicts alpha from the
// alpha row memory or from the bands below, and picks the band's matrix kind.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_alpha
  import sbm_pkg::*;
#(
  parameter int unsigned MAX_BANDS  = 64,
  parameter int unsigned MAX_GROUPS = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     rd_en_i,
  input  wire logic [5:0] rd_band_i,
  input  wire logic     hdr_valid_i,
  input  wire sbm_in_t  hdr_i,
  input  wire sbm_sap_e sap_mode_i,
  input  wire logic     pair_mode_i,
  input  wire logic     time_delta_i,
  output sbm_dec_t      dec_o
);

  localparam int unsigned AW = $clog2(MAX_BANDS);

  logic signed [ALPHA_W-1:0] alpha_mem [MAX_BANDS];
  logic signed [ALPHA_W-1:0] rdata_q;
  logic signed [ALPHA_W-1:0] fwd_data_q;
  logic                      fwd_hit_q;

  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic                      wr_en;
  logic signed [ALPHA_W-1:0] wr_data;

  logic [2:0]                cur_group_q;
  logic [6:0]                cur_count_q;
  logic [6:0]                prev_count_q;
  logic [6:0]                prev_count_d;
  logic signed [ALPHA_W-1:0] alpha_m1_q;
  logic signed [ALPHA_W-1:0] alpha_m2_q;

  logic                      hdr_fire;
  logic                      in_range;
  logic                      by_time;
  logic                      alpha_upd;
  logic signed [ALPHA_W-1:0] row_alpha;
  logic signed [9:0]         delta;
  logic signed [9:0]         base;
  logic signed [9:0]         sum;
  logic signed [ALPHA_W-1:0] sum_sat;
  logic signed [ALPHA_W-1:0] value;

  assign rd_addr  = AW'(rd_band_i);
  assign wr_addr  = AW'(hdr_i.band_index);
  assign hdr_fire = hdr_valid_i && en_i;

  // Alpha row memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      alpha_mem[wr_addr] <= wr_data;
    end
    if (en_i && rd_en_i) begin
      rdata_q <= alpha_mem[rd_addr];
    end
  end

  // A header reading the entry that the header ahead of it writes in the
  // same cycle takes the new value from the forwarding register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q  <= 1'b0;
      fwd_data_q <= '0;
    end else if (en_i && rd_en_i) begin
      fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
      fwd_data_q <= wr_data;
    end
  end

  assign row_alpha = fwd_hit_q ? fwd_data_q : rdata_q;

  // Group tracking: the previous count only counts when the group follows on.
  always_comb begin
    prev_count_d = prev_count_q;
    if (hdr_i.group_index != cur_group_q) begin
      if ({1'b0, hdr_i.group_index} == ({1'b0, cur_group_q} + 4'd1)) begin
        prev_count_d = cur_count_q;
      end else begin
        prev_count_d = '0;
      end
    end
  end

  assign in_range = ({1'b0, hdr_i.band_index} < hdr_i.group_band_count) &&
                    (32'(hdr_i.band_index) < MAX_BANDS) &&
                    (32'(hdr_i.group_index) < MAX_GROUPS);

  assign by_time = (hdr_i.group_index != 3'd0) &&
                   (hdr_i.group_band_count == prev_count_d) && time_delta_i;

  // DPCM decode of alpha with saturation to eight bits.
  always_comb begin
    delta = $signed({3'b000, hdr_i.alpha_code}) - $signed({3'b000, ALPHA_OFFSET});
    if (by_time) begin
      base = 10'(row_alpha);
    end else if (hdr_i.band_index == 6'd0) begin
      base = '0;
    end else begin
      base = 10'(alpha_m2_q);
    end
    sum = base + delta;
    if (sum > 10'sd127) begin
      sum_sat = 8'sd127;
    end else if (sum < -10'sd128) begin
      sum_sat = -8'sd128;
    end else begin
      sum_sat = sum[ALPHA_W-1:0];
    end
    if (!hdr_i.coefficient_used) begin
      value = '0;
    end else if (hdr_i.band_index[0]) begin
      value = alpha_m1_q;
    end else begin
      value = sum_sat;
    end
  end

  // Matrix kind for the band.
  always_comb begin
    dec_o.kind  = KIND_IDENT;
    dec_o.alpha = value;
    if (in_range) begin
      unique case (sap_mode_i)
        SAP_IDENTITY: dec_o.kind = KIND_IDENT;
        SAP_MS_BAND:  dec_o.kind = (pair_mode_i && hdr_i.mid_side_used) ?
                                   KIND_MID_SIDE : KIND_IDENT;
        SAP_MS_ALL:   dec_o.kind = pair_mode_i ? KIND_MID_SIDE : KIND_IDENT;
        SAP_PREDICT:  dec_o.kind = hdr_i.coefficient_used ? KIND_PREDICT : KIND_IDENT;
        default:      dec_o.kind = KIND_IDENT;
      endcase
    end
  end

  assign alpha_upd = hdr_fire && in_range && (sap_mode_i == SAP_PREDICT);
  assign wr_en     = alpha_upd;
  assign wr_data   = value;

  // Group and alpha history registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_group_q  <= '0;
      cur_count_q  <= '0;
      prev_count_q <= '0;
      alpha_m1_q   <= '0;
      alpha_m2_q   <= '0;
    end else begin
      if (hdr_fire) begin
        cur_group_q  <= hdr_i.group_index;
        cur_count_q  <= hdr_i.group_band_count;
        prev_count_q <= prev_count_d;
      end
      if (alpha_upd) begin
        alpha_m2_q <= alpha_m1_q;
        alpha_m1_q <= value;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sbm_matrix.sv -----
// ----------------------------------------------------------------------------
// Stereo band matrix coefficient stage
// Turns a header decision into the 2x2 Q14 matrix and holds it for the line
// pairs of the band.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_matrix
  import sbm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     hdr_valid_i,
  input  wire sbm_dec_t dec_i,
  input  wire logic     pair_mode_i,
  output sbm_matrix_t   coef_o
);

  sbm_matrix_t coef_q;
  sbm_matrix_t coef_d;
  sbm_coef_t   gain;

  assign gain = gain_q14(dec_i.alpha);

  // Next matrix from the header decision.
  always_comb begin
    coef_d = coef_q;
    if (hdr_valid_i && en_i) begin
      unique case (dec_i.kind)
        KIND_IDENT: begin
          coef_d = '{a: ONE_Q14, b: ZERO_Q14, c: ZERO_Q14, d: ONE_Q14};
        end
        KIND_MID_SIDE: begin
          coef_d = '{a: ONE_Q14, b: ONE_Q14, c: ONE_Q14, d: MINUS_ONE_Q14};
        end
        KIND_PREDICT: begin
          if (pair_mode_i) begin
            coef_d = '{a: ONE_Q14 + gain, b: ONE_Q14,
                       c: ONE_Q14 - gain, d: MINUS_ONE_Q14};
          end else begin
            coef_d = '{a: ONE_Q14, b: ZERO_Q14, c: gain, d: ONE_Q14};
          end
        end
        default: begin
          coef_d = '{a: ONE_Q14, b: ZERO_Q14, c: ZERO_Q14, d: ONE_Q14};
        end
      endcase
    end
  end

  // Matrix register, identity after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '{a: ONE_Q14, b: ZERO_Q14, c: ZERO_Q14, d: ONE_Q14};
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// ----- rtl/core/sbm_mix.sv -----
// ----------------------------------------------------------------------------
// Stereo band matrix mixer
// Multiplies a line pair by the band matrix, then sums, rounds and
// saturates the two outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module sbm_mix
  import sbm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          line_valid_i,
  input  wire logic signed [SAMPLE_BITS-1:0] left_i,
  input  wire logic signed [SAMPLE_BITS-1:0] right_i,
  input  wire sbm_matrix_t                   coef_i,
  output logic                               res_valid_o,
  output sbm_out_t                           res_o
);

  localparam int unsigned PROD_W = COEF_W + SAMPLE_BITS;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1 << (Q_FRAC - 1));

  logic signed [PROD_W-1:0] p_al_q;
  logic signed [PROD_W-1:0] p_br_q;
  logic signed [PROD_W-1:0] p_cl_q;
  logic signed [PROD_W-1:0] p_dr_q;
  logic                     prod_valid_q;

  // Round half up, drop the fraction and saturate to the sample width.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
    input logic signed [PROD_W-1:0] x,
    input logic signed [PROD_W-1:0] y
  );
    logic signed [SUM_W-1:0]                       s;
    logic [SUM_W-SAMPLE_BITS-Q_FRAC:0]             top;
    logic signed [SAMPLE_BITS-1:0]                 r;
    s   = SUM_W'(x) + SUM_W'(y) + RND;
    top = s[SUM_W-1:SAMPLE_BITS+Q_FRAC-1];
    if ((&top) || !(|top)) begin
      r = s[SAMPLE_BITS+Q_FRAC-1:Q_FRAC];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // Product registers: four multiplies in parallel.
  always_ff @(posedge clk_i) begin
    if (en_i && line_valid_i) begin
      p_al_q <= PROD_W'(coef_i.a) * PROD_W'(left_i);
      p_br_q <= PROD_W'(coef_i.b) * PROD_W'(right_i);
      p_cl_q <= PROD_W'(coef_i.c) * PROD_W'(left_i);
      p_dr_q <= PROD_W'(coef_i.d) * PROD_W'(right_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (en_i) begin
      prod_valid_q <= line_valid_i;
    end
  end

  assign res_valid_o     = prod_valid_q;
  assign res_o.out_left  = round_sat(p_al_q, p_br_q);
  assign res_o.out_right = round_sat(p_cl_q, p_dr_q);

endmodule

`default_nettype wire

// ----- rtl/core/stereo_band_matrix_decode_apply.sv -----
// ----------------------------------------------------------------------------
// Stereo band matrix decode and apply
// Decodes per-band stereo matrices from band headers and mixes the spectral
// line pairs that follow them.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, band headers and line pairs in
// any mix. A line pair's result returns from the output register; a header
// returns nothing but sets the matrix for later line pairs. The pipeline is
// a header stage that reads, updates and writes back the alpha row memory
// (one read and one write port, with forwarding for a header that reads the
// entry written by the header just ahead of it), a stage that builds the Q14
// matrix and forms four products, and a stage that rounds and saturates into
// the output register. The whole pipeline holds only while a result waits in
// the output register and the receiver stalls; otherwise an item enters
// every cycle. The alpha row gets no clearing after reset: the user must see
// that each entry is written before prediction across time reads it; the
// block has no check for this. Configuration is written through a port that
// is always ready and must only change while the block is idle.
`default_nettype none

module stereo_band_matrix_decode_apply
  import sbm_pkg::*;
#(
  parameter int unsigned MAX_BANDS  = 64,
  parameter int unsigned MAX_GROUPS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input items
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire sbm_in_t               in_data_i,
  // Result items
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output sbm_out_t                   out_data_o
);

  sbm_sap_e    sap_mode_q;
  logic        pair_mode_q;
  logic        time_delta_q;

  logic        en;
  logic        accept;

  logic        s1_valid_q;
  sbm_in_t     s1_item_q;
  logic        s2_valid_q;
  sbm_in_t     s2_item_q;
  sbm_dec_t    s2_dec_q;
  sbm_dec_t    dec;

  sbm_matrix_t coef;
  logic        res_valid;
  sbm_out_t    res;

  logic        out_valid_q;
  sbm_out_t    out_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sap_mode_q   <= SAP_IDENTITY;
      pair_mode_q  <= 1'b1;
      time_delta_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAP_MODE:   sap_mode_q   <= sbm_sap_e'(cfg_data_i[1:0]);
        CFG_PAIR_MODE:  pair_mode_q  <= cfg_data_i[0];
        CFG_TIME_DELTA: time_delta_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The pipeline advances unless a result waits on a stalled receiver.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;

  // Stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
    end
    if (en) begin
      s2_item_q <= s1_item_q;
      s2_dec_q  <= dec;
    end
  end

  // Header decode against the alpha row memory.
  sbm_alpha #(
    .MAX_BANDS  (MAX_BANDS),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_alpha (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .rd_en_i      (accept),
    .rd_band_i    (in_data_i.band_index),
    .hdr_valid_i  (s1_valid_q && (s1_item_q.action == ACT_HEADER)),
    .hdr_i        (s1_item_q),
    .sap_mode_i   (sap_mode_q),
    .pair_mode_i  (pair_mode_q),
    .time_delta_i (time_delta_q),
    .dec_o        (dec)
  );

  // Band matrix.
  sbm_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .hdr_valid_i (s2_valid_q && (s2_item_q.action == ACT_HEADER)),
    .dec_i       (s2_dec_q),
    .pair_mode_i (pair_mode_q),
    .coef_o      (coef)
  );

  // Line pair mixing.
  sbm_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .line_valid_i (s2_valid_q && (s2_item_q.action == ACT_LINE)),
    .left_i       (s2_item_q.line_left),
    .right_i      (s2_item_q.line_right),
    .coef_i       (coef),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Stereo band matrix decode and apply: self-checking testbench
// Drives band header and line pair items through the block with random
// idling on both sides. A behavioural predictor decodes each header into a
// 2x2 matrix and mixes each line pair, and every result item is compared
// field by field with the oldest expected mix.
// ----------------------------------------------------------------------------
module testbench
  import sbm_pkg::*;
();

  localparam int NUM_STEPS  = 34;
  localparam int ITEM_GOAL  = 600;
  localparam int CALM_AFTER = 500;
  localparam int SETTLE     = 8;
  localparam int LIMIT      = 400000;

  // One row of the directed table: either a register write or an item.
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    sbm_in_t               item;
    bit                    known;
    sbm_out_t              want;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  sbm_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  sbm_out_t              out_data_o;

  // Register copies and decoder state of the predictor.
  sbm_sap_e cfg_sap  = SAP_IDENTITY;
  bit       cfg_pair = 1'b1;
  bit       cfg_time = 1'b0;
  int       alpha_by_band [64];
  bit       alpha_band_known [64];
  int       alpha_last = 0;
  int       alpha_two_back = 0;
  int       prior_group_bands = 0;
  int       group_now = 0;
  int       group_bands_now = 0;
  int       mat [4] = '{16384, 0, 0, 16384};

  sbm_out_t pending_mix [$];
  step_t    plan [NUM_STEPS];
  bit       typed_on = 1'b0;
  sbm_out_t typed_want = '0;
  bit       failed = 1'b0;
  bit       calm = 1'b0;
  int       gap_pct = 10;
  int       stall_pct = 10;
  int       items_sent = 0;
  int       cycle_count = 0;

  stereo_band_matrix_decode_apply DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rounded, floored and saturated mix of one line pair with one matrix row.
  function automatic logic signed [SAMPLE_BITS-1:0] mix_lines(input int p, input int q,
                                                              input longint x,
                                                              input longint y);
    longint acc;
    longint top;
    top = longint'(1) <<< (SAMPLE_BITS - 1);
    acc = (longint'(p) * x + longint'(q) * y + (longint'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC;
    if (acc > top - 1) acc = top - 1;
    if (acc < -top) acc = -top;
    return acc[SAMPLE_BITS-1:0];
  endfunction

  // A header picks the matrix for the line pairs after it and, in prediction
  // mode, moves the alpha history along.
  function automatic void decode_band_header(input sbm_in_t h);
    int     unity;
    int     grp;
    int     band;
    int     count;
    int     value;
    int     gain;
    longint scaled;
    bit     by_time;
    unity = int'(ONE_Q14);
    grp   = int'(h.group_index);
    band  = int'(h.band_index);
    count = int'(h.group_band_count);
    if (grp != group_now) begin
      prior_group_bands = (grp == group_now + 1) ? group_bands_now : 0;
      group_now = grp;
    end
    group_bands_now = count;
    mat = '{unity, 0, 0, unity};
    if (band >= count) return;
    case (cfg_sap)
      SAP_IDENTITY: return;
      SAP_MS_BAND: begin
        if (cfg_pair && h.mid_side_used) mat = '{unity, unity, unity, -unity};
        return;
      end
      SAP_MS_ALL: begin
        if (cfg_pair) mat = '{unity, unity, unity, -unity};
        return;
      end
      default: ;
    endcase
    if (!h.coefficient_used) begin
      value = 0;
    end else begin
      if (band % 2 == 1) begin
        value = alpha_last;
      end else begin
        by_time = grp != 0 && count == prior_group_bands && cfg_time;
        value = int'(h.alpha_code) - int'(ALPHA_OFFSET);
        if (by_time) begin
          value += alpha_by_band[band];
        end else if (band != 0) begin
          value += alpha_two_back;
        end
      end
      if (value > 127) value = 127;
      if (value < -128) value = -128;
      // Gain is alpha times 0.1 in Q14, ties away from zero.
      scaled = longint'(value) * unity;
      gain = (scaled >= 0) ? int'((scaled + 5) / 10) : -int'((-scaled + 5) / 10);
      if (cfg_pair) mat = '{unity + gain, unity, unity - gain, -unity};
      else mat = '{unity, 0, gain, unity};
    end
    alpha_by_band[band] = value;
    alpha_band_known[band] = 1'b1;
    alpha_two_back = alpha_last;
    alpha_last = value;
  endfunction

  // True when a header would predict across time from an alpha entry that
  // has never been written.
  function automatic bit reads_unwritten_alpha(input sbm_in_t h);
    int grp;
    int prior;
    grp = int'(h.group_index);
    if (h.action != ACT_HEADER || cfg_sap != SAP_PREDICT) return 1'b0;
    if (!h.coefficient_used || h.band_index[0]) return 1'b0;
    if (h.band_index >= h.group_band_count) return 1'b0;
    prior = prior_group_bands;
    if (grp != group_now) prior = (grp == group_now + 1) ? group_bands_now : 0;
    if (grp == 0 || int'(h.group_band_count) != prior || !cfg_time) return 1'b0;
    return !alpha_band_known[h.band_index];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 4000)) - 32'd2000;
      default: return $urandom;
    endcase
  endfunction

  // A line pair item; the header fields carry random bits.
  function automatic sbm_in_t line_item();
    logic [95:0] bits;
    sbm_in_t     it;
    bits = {$urandom, $urandom, $urandom};
    it = bits[$bits(sbm_in_t)-1:0];
    it.action     = ACT_LINE;
    it.line_left  = pick_sample();
    it.line_right = pick_sample();
    return it;
  endfunction

  function automatic sbm_in_t header_item(input int grp, input int band, input int count);
    sbm_in_t it;
    it = line_item();
    it.action           = ACT_HEADER;
    it.group_index      = 3'(grp);
    it.band_index       = 6'(band);
    it.group_band_count = 7'(count);
    it.mid_side_used    = 1'($urandom_range(0, 1));
    it.coefficient_used = ($urandom_range(0, 4) != 0);
    it.alpha_code = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(52, 68))
                                                : 7'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic step_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s.is_reg    = 1'b1;
    s.reg_index = idx;
    s.reg_value = val;
    s.item      = '0;
    s.known     = 1'b0;
    s.want      = '0;
    return s;
  endfunction

  function automatic step_t row_header(input int grp, input int band, input int count,
                                       input bit ms, input bit cu, input int code);
    step_t s;
    s = row_reg(CFG_SAP_MODE, '0);
    s.is_reg = 1'b0;
    s.item = header_item(grp, band, count);
    s.item.mid_side_used    = ms;
    s.item.coefficient_used = cu;
    s.item.alpha_code       = 7'(code);
    return s;
  endfunction

  function automatic step_t row_line(input logic signed [SAMPLE_BITS-1:0] l,
                                     input logic signed [SAMPLE_BITS-1:0] r,
                                     input bit known = 1'b0,
                                     input logic signed [SAMPLE_BITS-1:0] wl = '0,
                                     input logic signed [SAMPLE_BITS-1:0] wr = '0);
    step_t s;
    s = row_reg(CFG_SAP_MODE, '0);
    s.is_reg = 1'b0;
    s.item = line_item();
    s.item.line_left  = l;
    s.item.line_right = r;
    s.known = known;
    s.want.out_left  = wl;
    s.want.out_right = wr;
    return s;
  endfunction

  // Presents one item from a falling edge and holds it until it is taken.
  task automatic send_item(input sbm_in_t it, input bit known = 1'b0,
                           input sbm_out_t want = '0);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    if (reads_unwritten_alpha(it)) it.coefficient_used = 1'b0;
    typed_on   = known;
    typed_want = want;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (items_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  // Stops sending, waits for every expected mix and lets the pipeline drain.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One frame of window groups: mostly well-formed band runs with line pairs,
  // with dropped bands, skipped groups and stray headers mixed in.
  task automatic play_frame();
    int grp;
    int count;
    int last_count;
    grp = 0;
    last_count = 1;
    while (grp < 8 && items_sent < ITEM_GOAL) begin
      if (grp > 0 && $urandom_range(0, 9) < 6) count = last_count;
      else if ($urandom_range(0, 15) == 0) count = 64;
      else count = $urandom_range(1, 10);
      for (int b = 0; b < count; b++) begin
        if (items_sent >= ITEM_GOAL) break;
        if ($urandom_range(0, 19) == 0) continue;
        if ($urandom_range(0, 11) == 0) begin
          send_item(header_item($urandom_range(0, 7), $urandom_range(0, 63),
                                $urandom_range(0, 64)));
        end
        send_item(header_item(grp, b, count));
        repeat ($urandom_range(0, (count > 16) ? 1 : 3)) send_item(line_item());
      end
      last_count = count;
      grp += ($urandom_range(0, 7) == 0) ? 2 : 1;
      if ($urandom_range(0, 5) == 0) break;
    end
  endtask

  // Receiver stalls in bursts.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Tracks register writes and accepted items, and checks each result item.
  always @(posedge clk_i) begin
    sbm_out_t want;
    sbm_out_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SAP_MODE:   cfg_sap  = sbm_sap_e'(cfg_data_i);
          CFG_PAIR_MODE:  cfg_pair = cfg_data_i[0];
          CFG_TIME_DELTA: cfg_time = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.action == ACT_HEADER) begin
          decode_band_header(in_data_i);
        end else begin
          want.out_left  = mix_lines(mat[0], mat[1], longint'($signed(in_data_i.line_left)),
                                     longint'($signed(in_data_i.line_right)));
          want.out_right = mix_lines(mat[2], mat[3], longint'($signed(in_data_i.line_left)),
                                     longint'($signed(in_data_i.line_right)));
          if (typed_on) want = typed_want;
          pending_mix = {pending_mix, want};
        end
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (pending_mix.size() == 0) begin
          $error("result item with nothing expected: out_left %0d, out_right %0d",
                 got.out_left, got.out_right);
          failed = 1'b1;
        end else begin
          want = pending_mix.pop_front();
          if (got.out_left !== want.out_left) begin
            $error("out_left: expected %0d, got %0d", want.out_left, got.out_left);
            failed = 1'b1;
          end
          if (got.out_right !== want.out_right) begin
            $error("out_right: expected %0d, got %0d", want.out_right, got.out_right);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("stereo_band_matrix_decode_apply: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    plan = '{
      // Identity after reset, at the sample extremes.
      row_line(32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff, 32'h8000_0000),
      row_line(-1, 1, 1, -1, 1),
      // Mid/side on every band, with saturation both ways.
      row_reg(CFG_SAP_MODE, SAP_MS_ALL),
      row_header(0, 0, 4, 0, 0, 60),
      row_line(32'h7fff_ffff, 32'h7fff_ffff, 1, 32'h7fff_ffff, 0),
      row_line(32'h8000_0000, 32'h7fff_ffff, 1, -1, 32'h8000_0000),
      // A band beyond the group's count falls back to identity.
      row_header(0, 5, 4, 0, 0, 60),
      row_line(12345, -777, 1, 12345, -777),
      // Per-band mid/side, flag set and clear.
      row_reg(CFG_SAP_MODE, SAP_MS_BAND),
      row_header(0, 1, 4, 1, 0, 60),
      row_line(100, 50, 1, 150, 50),
      row_header(0, 2, 4, 0, 0, 60),
      row_line(100, 50, 1, 100, 50),
      // Single-track use turns mid/side into identity.
      row_reg(CFG_PAIR_MODE, 0),
      row_header(0, 3, 4, 1, 0, 60),
      row_line(100, 50, 1, 100, 50),
      // Prediction: largest code, odd band copy, missing coefficient.
      row_reg(CFG_SAP_MODE, SAP_PREDICT),
      row_reg(CFG_TIME_DELTA, 1),
      row_header(0, 0, 4, 0, 1, 127),
      row_line(1000000, -3),
      row_reg(CFG_PAIR_MODE, 1),
      row_header(0, 1, 4, 0, 1, 0),
      row_line(32'h8000_0000, 32'h7fff_ffff),
      row_header(0, 2, 4, 0, 0, 60),
      row_line(5, 6, 1, 5, 6),
      row_header(0, 3, 4, 0, 1, 9),
      // Across time from the previous group with the same band count.
      row_header(1, 0, 4, 0, 1, 0),
      row_line(32'h0010_0000, 0),
      // Skipped groups predict across frequency; alpha saturates high.
      row_header(3, 0, 4, 0, 1, 127),
      row_header(3, 1, 4, 0, 1, 127),
      row_header(3, 2, 4, 0, 1, 127),
      row_line(32'h7fff_ffff, 32'h7fff_ffff),
      // Top group, top band, full count.
      row_header(7, 63, 64, 1, 1, 127),
      row_line(-1, -1)
    };
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table.
    for (int k = 0; k < NUM_STEPS; k++) begin
      if (plan[k].is_reg) begin
        wait_idle();
        write_reg(plan[k].reg_index, plan[k].reg_value);
      end else begin
        send_item(plan[k].item, plan[k].known, plan[k].want);
      end
    end

    // Random phases, each with its own settings and idling rates.
    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      write_reg(CFG_SAP_MODE, ($urandom_range(0, 1) != 0) ? 2'(SAP_PREDICT)
                                                          : 2'($urandom_range(0, 3)));
      write_reg(CFG_PAIR_MODE, 2'($urandom_range(0, 3) != 0));
      write_reg(CFG_TIME_DELTA, 2'($urandom_range(0, 2) != 0));
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 5;
        2: gap_pct = 20;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 5;
        2: stall_pct = 20;
        default: stall_pct = 40;
      endcase
      repeat ($urandom_range(1, 3)) play_frame();
    end

    wait_idle();
    if (!failed) begin
      $display("stereo_band_matrix_decode_apply: match");
    end else begin
      $display("stereo_band_matrix_decode_apply: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sbm_pkg.sv
rtl/core/sbm_alpha.sv
rtl/core/sbm_matrix.sv
rtl/core/sbm_mix.sv
rtl/core/stereo_band_matrix_decode_apply.sv
tb/sv/testbench.sv
